// ----- src/primitive_assembly_face_setup_assert.svh -----
// ----------------------------------------------------------------------------
// primitive_assembly_face_setup_assert.svh
// assertion shorthands used by the primitive assembly rtl
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLY_FACE_SETUP_ASSERT_SVH
`define PRIMITIVE_ASSEMBLY_FACE_SETUP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PAFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PAFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pafs_pkg.sv -----
// ----------------------------------------------------------------------------
// pafs_pkg
// widths, codes and result type for primitive assembly face setup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pafs_pkg;

    // default sizes of the vertex store and its coordinates
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 24;

    // fixed field widths on the streams
    localparam int IN_COORD_W = 24;
    localparam int IDX_W      = 10;
    localparam int MAT_W      = 16;
    localparam int KIND_W     = 2;
    localparam int NORMAL_W   = 50;
    localparam int CENTER_W   = 24;

    // index width wide enough to compare against the largest store depth
    localparam int IDX_EXT_W = 17;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 272;

    // result queue
    localparam int FIFO_DEPTH = 8;

    // center scale 0.33 as 21627 / 65536
    localparam int                 CENTER_SHIFT = 16;
    localparam logic signed [15:0] CENTER_MUL   = 16'sd21627;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SUBMIT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        TOPO_POINTS    = 2'd0,
        TOPO_LINES     = 2'd1,
        TOPO_TRIANGLES = 2'd2
    } topo_t;

    typedef enum logic {
        WIND_CW  = 1'b0,
        WIND_CCW = 1'b1
    } wind_t;

    typedef enum logic [1:0] {
        CFG_TOPOLOGY = 2'd0,
        CFG_WINDING  = 2'd1,
        CFG_MATERIAL = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [KIND_W-1:0]   prim_kind;
        logic [IDX_W-1:0]    first_index;
        logic [IDX_W-1:0]    second_index;
        logic [IDX_W-1:0]    third_index;
        logic [MAT_W-1:0]    prim_material;
        logic [NORMAL_W-1:0] normal_x;
        logic [NORMAL_W-1:0] normal_y;
        logic [NORMAL_W-1:0] normal_z;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [CENTER_W-1:0] center_z;
    } pafs_result_t;

endpackage

// ----- src/primitive_assembly_face_setup.sv -----
// ----------------------------------------------------------------------------
// primitive_assembly_face_setup
// assembles points, lines or triangles from an index stream, with face
// normal and center for triangles
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries load and submit items, tuser = opcode (0 load, 1 submit).
//   A load writes x, y, z into the vertex store; a submit reads the stored
//   position in the next cycle and adds it to the current group.
//   m_axis carries one primitive per finished group, tuser = primitive kind.
//   cfg_wr_en / cfg_index / cfg_wdata write topology (0), winding (1) and
//   material id (2); write only while the block is idle.
// Throughput and pipeline
//   One item per cycle while s_axis_tready is high; each item makes at most
//   one vertex store access. After the index that completes its group, its
//   result passes store read, multiply, subtract/shift and the queue to m_axis.
// Reset
//   Registers return to triangles, counterclockwise, material 0; the group,
//   the pipeline and the result queue empty. Store contents stay undefined.
// Stall
//   Results wait in an 8-entry queue; s_axis_tready falls only when queued
//   plus in-flight items would fill it, so loads and indices keep flowing
//   while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "primitive_assembly_face_setup_assert.svh"

module primitive_assembly_face_setup #(
    parameter int VERTEX_DEPTH = pafs_pkg::VERTEX_DEPTH_DEF,
    parameter int COORD_WIDTH  = pafs_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [pafs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pafs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, zero pad
    input  logic [pafs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // opcode
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // first_index, second_index, third_index, prim_material, normal_x,
    // normal_y, normal_z, center_x, center_y, center_z, zero pad
    output logic [pafs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // prim_kind
    output logic [pafs_pkg::KIND_W-1:0]        m_axis_tuser
);

    import pafs_pkg::*;

    localparam int ADDR_W     = $clog2(VERTEX_DEPTH);
    localparam int POS_W      = 3 * COORD_WIDTH;
    localparam int EDGE_W     = COORD_WIDTH + 1;
    localparam int SUM_W      = COORD_WIDTH + 2;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int NEXT_W     = (DIFF_W > NORMAL_W) ? DIFF_W : NORMAL_W;
    localparam int CPROD_W    = SUM_W + 16;
    localparam int CEXT_W     = (CPROD_W > CENTER_W) ? CPROD_W : CENTER_W;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = FIFO_PTR_W + 2;
    localparam int PAD_W      = M_TDATA_W - 3 * IDX_W - MAT_W - 3 * NORMAL_W - 3 * CENTER_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [KIND_W-1:0] topology_reg;
    logic              winding_reg;
    logic [MAT_W-1:0]  material_reg;
    logic              cfg_topo_wr;

    assign cfg_topo_wr = cfg_wr_en && (cfg_index == CFG_TOPOLOGY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= TOPO_TRIANGLES;
            winding_reg  <= WIND_CCW;
            material_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TOPOLOGY: topology_reg <= cfg_wdata[KIND_W-1:0];
                CFG_WINDING:  winding_reg  <= cfg_wdata[0];
                CFG_MATERIAL: material_reg <= cfg_wdata[MAT_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input unpack and vertex store access
    // ------------------------------------------------------------------
    logic                         in_xfer;
    logic [IDX_W-1:0]             in_idx;
    logic [IDX_EXT_W-1:0]         in_idx_ext;
    logic                         in_range;
    logic signed [IN_COORD_W-1:0] in_px;
    logic signed [IN_COORD_W-1:0] in_py;
    logic signed [IN_COORD_W-1:0] in_pz;
    logic                         in_submit;
    logic                         store_wr_en;
    logic                         store_rd_en;
    logic [POS_W-1:0]             store_wr_data;
    logic [POS_W-1:0]             store_rd_data;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign in_idx     = s_axis_tdata[IDX_W-1:0];
    assign in_px      = s_axis_tdata[IDX_W +: IN_COORD_W];
    assign in_py      = s_axis_tdata[IDX_W + IN_COORD_W +: IN_COORD_W];
    assign in_pz      = s_axis_tdata[IDX_W + 2 * IN_COORD_W +: IN_COORD_W];
    assign in_idx_ext = IDX_EXT_W'(in_idx);
    assign in_range   = in_idx_ext < IDX_EXT_W'(VERTEX_DEPTH);

    // submits are dropped while topology holds the unused code
    assign in_submit = in_xfer && (s_axis_tuser == OP_SUBMIT)
                       && (topology_reg inside {TOPO_POINTS, TOPO_LINES, TOPO_TRIANGLES});

    assign store_wr_en   = in_xfer && (s_axis_tuser == OP_LOAD) && in_range;
    assign store_rd_en   = in_submit && in_range;
    assign store_wr_data = {COORD_WIDTH'(in_pz), COORD_WIDTH'(in_py), COORD_WIDTH'(in_px)};

    pafs_ram #(
        .WIDTH (POS_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_store (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (in_idx_ext[ADDR_W-1:0]),
        .wr_data (store_wr_data),
        .rd_en   (store_rd_en),
        .rd_addr (in_idx_ext[ADDR_W-1:0]),
        .rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------
    // stage 1: store data returns, group assembly
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_submit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_submit)
        begin
            s1_idx_reg      <= in_idx;
            s1_in_range_reg <= in_range;
        end
    end

    logic [1:0]                   group_count_reg;
    logic [1:0]                   group_count_next;
    logic [IDX_W-1:0]             pend_idx_reg [2];
    logic [POS_W-1:0]             pend_pos_reg [2];
    logic [POS_W-1:0]             s1_pos;
    logic                         s1_complete;
    logic                         s1_tri;
    logic signed [COORD_WIDTH-1:0] cur_c [3];
    logic signed [COORD_WIDTH-1:0] v0_c  [3];
    logic signed [COORD_WIDTH-1:0] v1_c  [3];
    logic signed [EDGE_W-1:0]      e01   [3];
    logic signed [EDGE_W-1:0]      e02   [3];
    logic signed [EDGE_W-1:0]      s1_a  [3];
    logic signed [EDGE_W-1:0]      s1_b  [3];
    logic signed [SUM_W-1:0]       s1_sum [3];
    logic [IDX_W-1:0]              s1_first;
    logic [IDX_W-1:0]              s1_second;
    logic [IDX_W-1:0]              s1_third;

    // an index outside the store reads a zero position
    assign s1_pos      = s1_in_range_reg ? store_rd_data : '0;
    assign s1_complete = group_count_reg >= topology_reg;
    assign s1_tri      = topology_reg == TOPO_TRIANGLES;

    // edges, winding order and coordinate sums
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cur_c[k] = s1_pos[k * COORD_WIDTH +: COORD_WIDTH];
            v0_c[k]  = pend_pos_reg[0][k * COORD_WIDTH +: COORD_WIDTH];
            v1_c[k]  = pend_pos_reg[1][k * COORD_WIDTH +: COORD_WIDTH];
            e01[k]   = EDGE_W'(v1_c[k]) - EDGE_W'(v0_c[k]);
            e02[k]   = EDGE_W'(cur_c[k]) - EDGE_W'(v0_c[k]);
            if (!s1_tri)
            begin
                s1_a[k]   = '0;
                s1_b[k]   = '0;
                s1_sum[k] = '0;
            end
            else
            begin
                s1_a[k]   = (winding_reg == WIND_CCW) ? e01[k] : e02[k];
                s1_b[k]   = (winding_reg == WIND_CCW) ? e02[k] : e01[k];
                s1_sum[k] = SUM_W'(v0_c[k]) + SUM_W'(v1_c[k]) + SUM_W'(cur_c[k]);
            end
        end
    end

    // vertex indices by primitive kind
    always_comb
    begin
        s1_first  = pend_idx_reg[0];
        s1_second = '0;
        s1_third  = '0;
        case (topology_reg)
            TOPO_POINTS:
            begin
                s1_first = s1_idx_reg;
            end
            TOPO_LINES:
            begin
                s1_second = s1_idx_reg;
            end
            TOPO_TRIANGLES:
            begin
                s1_second = pend_idx_reg[1];
                s1_third  = s1_idx_reg;
            end
            default: ;
        endcase
    end

    // group counter, cleared by a topology write
    always_comb
    begin
        group_count_next = group_count_reg;
        if (cfg_topo_wr)
        begin
            group_count_next = '0;
        end
        else if (s1_valid_reg)
        begin
            group_count_next = s1_complete ? 2'd0 : group_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= '0;
        end
        else
        begin
            group_count_reg <= group_count_next;
        end
    end

    // capture index and position of a pending vertex
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s1_complete)
        begin
            pend_idx_reg[group_count_reg[0]] <= s1_idx_reg;
            pend_pos_reg[group_count_reg[0]] <= s1_pos;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cross product and center multiplies
    // ------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic [KIND_W-1:0]        s2_kind_reg;
    logic [IDX_W-1:0]         s2_first_reg;
    logic [IDX_W-1:0]         s2_second_reg;
    logic [IDX_W-1:0]         s2_third_reg;
    logic [MAT_W-1:0]         s2_mat_reg;
    logic signed [EDGE_W-1:0] s2_a_reg   [3];
    logic signed [EDGE_W-1:0] s2_b_reg   [3];
    logic signed [SUM_W-1:0]  s2_sum_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_complete;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_complete)
        begin
            s2_kind_reg   <= topology_reg;
            s2_first_reg  <= s1_first;
            s2_second_reg <= s1_second;
            s2_third_reg  <= s1_third;
            s2_mat_reg    <= material_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_a_reg[k]   <= s1_a[k];
                s2_b_reg[k]   <= s1_b[k];
                s2_sum_reg[k] <= s1_sum[k];
            end
        end
    end

    logic signed [PROD_W-1:0]  s2_prod  [6];
    logic signed [CPROD_W-1:0] s2_cprod [3];

    // products in the order ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx
    assign s2_prod[0] = s2_a_reg[1] * s2_b_reg[2];
    assign s2_prod[1] = s2_a_reg[2] * s2_b_reg[1];
    assign s2_prod[2] = s2_a_reg[2] * s2_b_reg[0];
    assign s2_prod[3] = s2_a_reg[0] * s2_b_reg[2];
    assign s2_prod[4] = s2_a_reg[0] * s2_b_reg[1];
    assign s2_prod[5] = s2_a_reg[1] * s2_b_reg[0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s2_cprod[k] = s2_sum_reg[k] * CENTER_MUL;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: normal differences and floored center
    // ------------------------------------------------------------------
    logic                      s3_valid_reg;
    logic [KIND_W-1:0]         s3_kind_reg;
    logic [IDX_W-1:0]          s3_first_reg;
    logic [IDX_W-1:0]          s3_second_reg;
    logic [IDX_W-1:0]          s3_third_reg;
    logic [MAT_W-1:0]          s3_mat_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg  [6];
    logic signed [CPROD_W-1:0] s3_cprod_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_kind_reg   <= s2_kind_reg;
            s3_first_reg  <= s2_first_reg;
            s3_second_reg <= s2_second_reg;
            s3_third_reg  <= s2_third_reg;
            s3_mat_reg    <= s2_mat_reg;
            for (int k = 0; k < 6; k++)
            begin
                s3_prod_reg[k] <= s2_prod[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                s3_cprod_reg[k] <= s2_cprod[k];
            end
        end
    end

    logic signed [DIFF_W-1:0]  s3_diff  [3];
    logic signed [NEXT_W-1:0]  s3_nwide [3];
    logic signed [CPROD_W-1:0] s3_cshift [3];
    logic signed [CEXT_W-1:0]  s3_cwide [3];
    pafs_result_t              s3_result;

    // normal wraps to its field, arithmetic shift floors the center
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_diff[k]   = DIFF_W'(s3_prod_reg[2 * k]) - DIFF_W'(s3_prod_reg[2 * k + 1]);
            s3_nwide[k]  = NEXT_W'(s3_diff[k]);
            s3_cshift[k] = s3_cprod_reg[k] >>> CENTER_SHIFT;
            s3_cwide[k]  = CEXT_W'(s3_cshift[k]);
        end
        s3_result.prim_kind     = s3_kind_reg;
        s3_result.first_index   = s3_first_reg;
        s3_result.second_index  = s3_second_reg;
        s3_result.third_index   = s3_third_reg;
        s3_result.prim_material = s3_mat_reg;
        s3_result.normal_x      = s3_nwide[0][NORMAL_W-1:0];
        s3_result.normal_y      = s3_nwide[1][NORMAL_W-1:0];
        s3_result.normal_z      = s3_nwide[2][NORMAL_W-1:0];
        s3_result.center_x      = s3_cwide[0][CENTER_W-1:0];
        s3_result.center_y      = s3_cwide[1][CENTER_W-1:0];
        s3_result.center_z      = s3_cwide[2][CENTER_W-1:0];
    end

    // ------------------------------------------------------------------
    // result queue and credit based input ready
    // ------------------------------------------------------------------
    pafs_result_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   fifo_wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   fifo_rd_ptr_reg;
    logic [FIFO_PTR_W:0]     fifo_count_reg;
    logic [FIFO_PTR_W:0]     fifo_count_next;
    logic                    fifo_push;
    logic                    fifo_pop;
    logic [CREDIT_W-1:0]     credit_used;
    pafs_result_t            out_result;

    assign fifo_push = s3_valid_reg;
    assign fifo_pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (fifo_push && !fifo_pop)
        begin
            fifo_count_next = fifo_count_reg + 1'b1;
        end
        else if (fifo_pop && !fifo_push)
        begin
            fifo_count_next = fifo_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_count_reg  <= '0;
        end
        else
        begin
            if (fifo_push)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + 1'b1;
            end
            if (fifo_pop)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + 1'b1;
            end
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem_reg[fifo_wr_ptr_reg] <= s3_result;
        end
    end

    // every index in flight may still need a queue slot
    assign credit_used = CREDIT_W'(fifo_count_reg) + CREDIT_W'(s1_valid_reg)
                         + CREDIT_W'(s2_valid_reg) + CREDIT_W'(s3_valid_reg);
    assign s_axis_tready = credit_used < CREDIT_W'(FIFO_DEPTH);

    // output pack
    assign out_result    = fifo_mem_reg[fifo_rd_ptr_reg];
    assign m_axis_tvalid = fifo_count_reg != '0;
    assign m_axis_tuser  = out_result.prim_kind;
    assign m_axis_tdata  = {PAD_W'(0),
                            out_result.center_z, out_result.center_y, out_result.center_x,
                            out_result.normal_z, out_result.normal_y, out_result.normal_x,
                            out_result.prim_material,
                            out_result.third_index, out_result.second_index,
                            out_result.first_index};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PAFS_ASSERT_NOW(a_fifo_no_overflow, fifo_push && !fifo_pop,
        fifo_count_reg != (FIFO_PTR_W + 1)'(FIFO_DEPTH), "result queue overflow")

    `PAFS_ASSERT_NOW(a_credit_bound, 1'b1,
        credit_used <= CREDIT_W'(FIFO_DEPTH), "queued plus in-flight exceeds queue")

    `PAFS_ASSERT_NOW(a_group_bound, s1_valid_reg,
        group_count_reg <= topology_reg, "group count past primitive size")

    `PAFS_ASSERT_NEXT(a_load_no_group, in_xfer && s_axis_tuser == OP_LOAD,
        !s1_valid_reg, "load item entered group assembly")

    `PAFS_ASSERT_NOW(a_flat_zero_normal, m_axis_tvalid && m_axis_tuser != TOPO_TRIANGLES,
        out_result.normal_x == '0 && out_result.center_x == '0,
        "non-triangle carries face data")

endmodule

// ----- src/pafs_ram.sv -----
// ----------------------------------------------------------------------------
// pafs_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
